@@ design/weighted_swap_type_selector_unit_defines.svh @@
// Assertion macros shared by the weighted swap type selector.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef WEIGHTED_SWAP_TYPE_SELECTOR_UNIT_DEFINES_SVH
`define WEIGHTED_SWAP_TYPE_SELECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wss: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define WSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wss: next-cycle check failed");

`endif

@@ design/wss_pkg.sv @@
// Package of the weighted swap type selector: sizes, codes and the
// command and status bundles between controller and datapath. No dependencies.
package wss_pkg;

  localparam int MAX_TYPES      = 64;
  localparam int COUNT_BITS     = 16;
  localparam int ADDR_BITS      = $clog2(MAX_TYPES);
  localparam int CNT_BITS       = $clog2(MAX_TYPES + 1);
  localparam int WEIGHT_BITS    = 2 * COUNT_BITS;
  localparam int ENTRY_BITS     = 2 * COUNT_BITS;

  localparam int TYPE_BITS      = 6;
  localparam int FIELD_CNT_BITS = 16;
  localparam int FRAC_BITS      = 32;
  localparam int TOTAL_BITS     = 38;
  localparam int TOTAL_HI_BITS  = TOTAL_BITS - FRAC_BITS;
  localparam int USE_BITS       = 7;
  localparam int CFG_DATA_BITS  = 7;
  localparam int CFG_IDX_BITS   = 1;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_DRAW  = 1'b1
  } wss_req_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SELECTION_MODE = 1'b0,
    CFG_TYPES_IN_USE   = 1'b1
  } wss_cfg_e;

  typedef enum logic {
    MODE_CANONICAL = 1'b0,
    MODE_GRAND     = 1'b1
  } wss_mode_e;

  typedef struct packed {
    logic write_entry;
    logic start;
    logic issue;
    logic end_sum;
    logic scale_mul;
    logic scale_add;
    logic search;
    logic load_out;
  } wss_cmd_t;

  typedef struct packed {
    logic more;
    logic pipe_busy;
    logic total_zero;
    logic out_free;
  } wss_status_t;

endpackage

@@ design/weighted_swap_type_selector_unit.sv @@
// Top level of the weighted swap type selector: controller plus datapath.
// Uses wss_pkg, wss_ctrl, wss_datapath and the assertion macro header.
//
// Usage. The input channel (in_valid_i / in_stall_o) carries one beat per
// request. A write beat (req_type_i = 0) stores both candidate counts of one
// swap type in a 64-entry table and leaves the channel unstalled. A draw beat
// (req_type_i = 1) walks the types in use through the table RAM: once to
// total the weights (count_a * count_b, or count_a alone in grand canonical
// mode) and, unless the total is zero, once more to find the first type
// whose running sum exceeds floor(random_fraction * total / 2^32). Each walk
// reads through the single RAM read port and the two-stage weight pipeline.
// The next beat can be taken as soon as the result is in the output register.
// Each draw gives one result beat on out_valid_o / out_stall_i; a write gives
// none. A zero total raises no_events_o with chosen type zero. The result
// sits in an output register, so a stalled receiver does not stop new beats
// being taken; only a second draw finishing while the first result is still
// held waits for it. Reset empties the table (every entry reads as zero until
// written), selects canonical mode and one type in use. The user must write
// the configuration port only while the block is idle; the block itself does
// not enforce this.
`include "weighted_swap_type_selector_unit_defines.svh"

module weighted_swap_type_selector_unit
  import wss_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      req_type_i,
  input  logic [TYPE_BITS-1:0]      type_index_i,
  input  logic [FIELD_CNT_BITS-1:0] count_first_i,
  input  logic [FIELD_CNT_BITS-1:0] count_second_i,
  input  logic [FRAC_BITS-1:0]      random_fraction_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [TYPE_BITS-1:0]      chosen_type_o,
  output logic                      no_events_o,
  output logic [TOTAL_BITS-1:0]     total_weight_o
);

  wss_cmd_t    cmd;
  wss_status_t status;

  // The controller sequences the passes; the datapath holds the table and data.
  wss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wss_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .type_index_i      (type_index_i),
    .count_first_i     (count_first_i),
    .count_second_i    (count_second_i),
    .random_fraction_i (random_fraction_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .chosen_type_o     (chosen_type_o),
    .no_events_o       (no_events_o),
    .total_weight_o    (total_weight_o)
  );

  // A result with no events carries a zero type and a zero total.
  `WSS_ASSERT_NOW(a_no_events_zero, out_valid_o && no_events_o, {chosen_type_o, total_weight_o} == '0)
  // A result with events always has a non-zero total.
  `WSS_ASSERT_NOW(a_events_nonzero, out_valid_o && !no_events_o, total_weight_o != '0)
  // A draw that is taken keeps the input side busy in the next cycle.
  `WSS_ASSERT_NEXT(a_draw_busy, in_valid_i && !in_stall_o && (req_type_i == REQ_DRAW), in_stall_o)
  // The output register is loaded only when it is free or being emptied.
  `WSS_ASSERT_NOW(a_load_when_free, cmd.load_out, status.out_free)

endmodule

@@ design/wss_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/wss_datapath.sv @@
// Datapath of the weighted swap type selector: count table, weight pipeline,
// threshold scaling, prefix search and output register. Uses wss_pkg, wss_ram.
module wss_datapath
  import wss_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wss_cmd_t                  cmd_i,
  output wss_status_t               status_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic [TYPE_BITS-1:0]      type_index_i,
  input  logic [FIELD_CNT_BITS-1:0] count_first_i,
  input  logic [FIELD_CNT_BITS-1:0] count_second_i,
  input  logic [FRAC_BITS-1:0]      random_fraction_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic [TYPE_BITS-1:0]      chosen_type_o,
  output logic                      no_events_o,
  output logic [TOTAL_BITS-1:0]     total_weight_o
);

  logic                      mode_q;
  logic [USE_BITS-1:0]       types_q;
  logic [CNT_BITS-1:0]       n_eff;

  logic [MAX_TYPES-1:0]      valid_q;
  logic                      wr_en;
  logic [ADDR_BITS-1:0]      waddr;
  logic [ENTRY_BITS-1:0]     wdata;
  logic [ADDR_BITS-1:0]      raddr;
  logic [ENTRY_BITS-1:0]     rdata;

  logic [CNT_BITS-1:0]       addr_q;
  logic                      v1_q, v2_q, vb1_q;
  logic [ADDR_BITS-1:0]      idx1_q, idx2_q;
  logic [COUNT_BITS-1:0]     cnt_a, cnt_b;
  logic [WEIGHT_BITS-1:0]    weight, w2_q;

  logic [TOTAL_BITS-1:0]     acc_q, total_q, thr_q, run_next;
  logic [FRAC_BITS-1:0]      frac_q;
  logic [2*FRAC_BITS-1:0]    prod_lo_q;
  logic [TOTAL_BITS-1:0]     prod_hi_q;
  logic                      found_q;
  logic [ADDR_BITS-1:0]      chosen_q;
  logic                      out_valid_q;

  assign n_eff = (int'(types_q) > MAX_TYPES) ? CNT_BITS'(MAX_TYPES) : CNT_BITS'(types_q);

  // Table write; an index past the table is dropped.
  assign wr_en = cmd_i.write_entry && (int'(type_index_i) < MAX_TYPES);
  assign waddr = ADDR_BITS'(type_index_i);
  assign wdata = {COUNT_BITS'(count_first_i), COUNT_BITS'(count_second_i)};
  assign raddr = addr_q[ADDR_BITS-1:0];

  wss_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (MAX_TYPES)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cnt_a = rdata[ENTRY_BITS-1:COUNT_BITS];
  assign cnt_b = rdata[COUNT_BITS-1:0];

  // Entries never written since reset read as zero counts.
  always_comb begin
    if (!vb1_q) begin
      weight = '0;
    end else if (mode_q == MODE_GRAND) begin
      weight = WEIGHT_BITS'(cnt_a);
    end else begin
      weight = WEIGHT_BITS'(cnt_a) * WEIGHT_BITS'(cnt_b);
    end
  end

  assign run_next = acc_q + TOTAL_BITS'(w2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CANONICAL;
      types_q     <= USE_BITS'(1);
      valid_q     <= '0;
      addr_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (wss_cfg_e'(cfg_index_i))
          CFG_SELECTION_MODE: mode_q  <= cfg_data_i[0];
          CFG_TYPES_IN_USE:   types_q <= cfg_data_i[USE_BITS-1:0];
          default: ;
        endcase
      end
      if (wr_en) begin
        valid_q[waddr] <= 1'b1;
      end
      if (cmd_i.start || cmd_i.end_sum) begin
        addr_q  <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.issue) begin
        addr_q <= addr_q + CNT_BITS'(1);
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.search && v2_q && !found_q && (run_next > thr_q)) begin
        found_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vb1_q  <= valid_q[raddr];
    idx1_q <= raddr;
    idx2_q <= idx1_q;
    w2_q   <= weight;
    if (cmd_i.start) begin
      frac_q <= random_fraction_i;
    end
    if (cmd_i.start || cmd_i.end_sum) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= run_next;
    end
    if (cmd_i.end_sum) begin
      total_q <= acc_q;
    end
    if (cmd_i.scale_mul) begin
      prod_lo_q <= (2*FRAC_BITS)'(total_q[FRAC_BITS-1:0]) * (2*FRAC_BITS)'(frac_q);
      prod_hi_q <= TOTAL_BITS'(total_q[TOTAL_BITS-1:FRAC_BITS]) * TOTAL_BITS'(frac_q);
    end
    if (cmd_i.scale_add) begin
      thr_q <= prod_hi_q + TOTAL_BITS'(prod_lo_q[2*FRAC_BITS-1:FRAC_BITS]);
    end
    if (cmd_i.search && v2_q && !found_q && (run_next > thr_q)) begin
      chosen_q <= idx2_q;
    end
    if (cmd_i.load_out) begin
      chosen_type_o  <= status_o.total_zero ? '0 : TYPE_BITS'(chosen_q);
      no_events_o    <= status_o.total_zero;
      total_weight_o <= total_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o.more        = (addr_q < n_eff);
  assign status_o.pipe_busy   = v1_q || v2_q;
  assign status_o.total_zero  = (total_q == '0);
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

@@ design/wss_ctrl.sv @@
// Controller of the weighted swap type selector: one-hot sequencer for the
// summing pass, scaling, search pass and result hand-over. Uses wss_pkg.
module wss_ctrl
  import wss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        req_type_i,
  output logic        in_stall_o,
  input  wss_status_t status_i,
  output wss_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_SUM       = 6'b000010,
    ST_SCALE_MUL = 6'b000100,
    ST_SCALE_ADD = 6'b001000,
    ST_SEARCH    = 6'b010000,
    ST_FINISH    = 6'b100000
  } wss_state_e;

  wss_state_e state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_DRAW) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SUM;
          end else begin
            cmd_o.write_entry = 1'b1;
          end
        end
      end
      ST_SUM: begin
        cmd_o.issue = status_i.more;
        if (!status_i.more && !status_i.pipe_busy) begin
          cmd_o.end_sum = 1'b1;
          state_d       = ST_SCALE_MUL;
        end
      end
      ST_SCALE_MUL: begin
        cmd_o.scale_mul = 1'b1;
        state_d = status_i.total_zero ? ST_FINISH : ST_SCALE_ADD;
      end
      ST_SCALE_ADD: begin
        cmd_o.scale_add = 1'b1;
        state_d         = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        cmd_o.issue  = status_i.more;
        if (!status_i.more && !status_i.pipe_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
